// ===== src/gbs_pkg.sv =====
// Shared constants and types for the greedy box suppression block.
`default_nettype none
package gbs_pkg;

  localparam int SCORE_W   = 16;
  localparam int LABEL_W   = 7;
  localparam int THR_W     = 9;
  localparam int ONE_PIXEL = 16;
  localparam int THR_SHIFT = 8;
  localparam int JOB_CNT_W = 11;

  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  // Register index, taken from bit 2 of the byte address.
  localparam logic [0:0] REG_IOU_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [JOB_CNT_W-1:0] count;
    logic                 overflow;
  } job_t;

endpackage
`default_nettype wire

// ===== src/greedy_box_suppression.sv =====
// Top level of the greedy box suppression block: register port, loader, queue and engine.
//
//  Channel  Direction  Transaction
//  s_*      in         one box; tlast marks the last box of a set
//  m_*      out        one kept box; tlast marks the last kept box, tuser the overflow flag
//  APB      in/out     threshold register at byte address 0
//
// Loading takes one box per cycle while s_tready is high. After the last box the engine runs
// score-ordered scans of the box store and tests each candidate in the overlap pipeline
// against the kept boxes. New boxes are refused from the last box of a set until its final
// result is loaded. Reset is synchronous and needs no clearing pass. Results wait in an
// output register.
`default_nettype none
module greedy_box_suppression #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: box_x1, box_y1, box_x2, box_y2, box_score, box_label, zero padding
  input  wire logic [((4*COORD_BITS+23+7)/8)*8-1:0] s_tdata,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: kept_x1, kept_y1, kept_x2, kept_y2, kept_score, kept_label, zero padding
  output logic [((4*COORD_BITS+23+7)/8)*8-1:0] m_tdata,
  output logic             m_tlast,
  // m_tuser: capacity_overflow
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int TW = ((4*COORD_BITS + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W + 7) / 8) * 8;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int FW = 4*COORD_BITS + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;

  logic [gbs_pkg::THR_W-1:0] thr;
  logic                      reg_sel;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [FW-1:0]             wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [FW-1:0]             rd_data;
  logic                      job_push;
  logic                      job_ready;
  gbs_pkg::job_t             push_job;
  gbs_pkg::job_t             pop_job;
  logic                      job_valid;
  logic                      job_pop;
  logic                      set_done;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == gbs_pkg::REG_IOU_THRESHOLD);
  assign prdata  = reg_sel ? 32'(thr) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= gbs_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr <= pwdata[gbs_pkg::THR_W-1:0];
    end
  end

  gbs_ram #(.W(FW), .D(MAX_BOXES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gbs_front #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .TW(TW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_push  (job_push),
    .job       (push_job),
    .job_ready (job_ready),
    .set_done  (set_done)
  );

  gbs_jobq u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .push_ready (job_ready),
    .pop        (job_pop),
    .pop_job    (pop_job),
    .pop_valid  (job_valid)
  );

  gbs_back #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS), .TW(TW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .thr         (thr),
    .job_valid   (job_valid),
    .job         (pop_job),
    .job_pop     (job_pop),
    .box_rd_en   (rd_en),
    .box_rd_addr (rd_addr),
    .box_rd_data (rd_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser),
    .set_done    (set_done)
  );

endmodule
`default_nettype wire

// ===== src/gbs_ram.sv =====
// Generic single write port RAM with a registered read port.
`default_nettype none
module gbs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] wr_addr,
  input  wire logic [W-1:0]                     wr_data,
  input  wire logic                             rd_en,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] rd_addr,
  output logic      [W-1:0]                     rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/gbs_jobq.sv =====
// Two entry queue of set descriptors between the loader and the suppression engine.
`default_nettype none
module gbs_jobq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire gbs_pkg::job_t push_job,
  output logic               push_ready,
  input  wire logic          pop,
  output gbs_pkg::job_t      pop_job,
  output logic               pop_valid
);

  gbs_pkg::job_t q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    fill;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_job    = q[rp];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      q[wp] <= push_job;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wp <= ~wp;
      end
      if (pop && pop_valid) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push && push_ready) - 2'(pop && pop_valid);
    end
  end

endmodule
`default_nettype wire

// ===== src/gbs_front.sv =====
// Loader: accepts boxes, fills the box store and hands finished sets to the queue.
`default_nettype none
module gbs_front #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16,
  parameter int TW         = 88
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     s_tvalid,
  output logic                                          s_tready,
  input  wire logic [TW-1:0]                            s_tdata,
  input  wire logic                                     s_tlast,
  output logic                                          wr_en,
  output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] wr_addr,
  output logic [4*COORD_BITS+gbs_pkg::SCORE_W+gbs_pkg::LABEL_W-1:0] wr_data,
  output logic                                          job_push,
  output gbs_pkg::job_t                                 job,
  input  wire logic                                     job_ready,
  input  wire logic                                     set_done
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int FW = 4*COORD_BITS + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;

  logic [CW-1:0] count;
  logic          overflow;
  logic          locked;
  logic          take;
  logic          room;
  logic [CW-1:0] count_after;

  assign s_tready    = !locked && job_ready;
  assign take        = s_tvalid && s_tready;
  assign room        = (count < CW'(MAX_BOXES));
  assign count_after = room ? count + CW'(1) : count;

  assign wr_en   = take && room;
  assign wr_addr = count[AW-1:0];
  assign wr_data = s_tdata[FW-1:0];

  assign job_push       = take && s_tlast;
  assign job.count      = gbs_pkg::JOB_CNT_W'(count_after);
  assign job.overflow   = overflow || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      locked   <= 1'b0;
    end else begin
      if (set_done) begin
        locked <= 1'b0;
      end
      if (take) begin
        if (s_tlast) begin
          count    <= '0;
          overflow <= 1'b0;
          locked   <= 1'b1;
        end else begin
          count    <= count_after;
          overflow <= overflow || !room;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/gbs_back.sv =====
// Suppression engine: picks boxes in score order, tests them against kept boxes, emits results.
`default_nettype none
module gbs_back #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16,
  parameter int TW         = 88
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic [gbs_pkg::THR_W-1:0]                thr,
  input  wire logic                                     job_valid,
  input  wire gbs_pkg::job_t                            job,
  output logic                                          job_pop,
  output logic                                          box_rd_en,
  output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] box_rd_addr,
  input  wire logic [4*COORD_BITS+gbs_pkg::SCORE_W+gbs_pkg::LABEL_W-1:0] box_rd_data,
  output logic                                          m_tvalid,
  input  wire logic                                     m_tready,
  output logic [TW-1:0]                                 m_tdata,
  output logic                                          m_tlast,
  output logic                                          m_tuser,
  output logic                                          set_done
);

  localparam int CB  = COORD_BITS;
  localparam int AW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW  = $clog2(MAX_BOXES + 1);
  localparam int FW  = 4*CB + gbs_pkg::SCORE_W + gbs_pkg::LABEL_W;
  localparam int DW  = CB + 2;
  localparam int PW  = 2*DW;
  localparam int UW  = PW + 1;
  localparam int MW  = UW + gbs_pkg::THR_W + 1;
  localparam int SW  = gbs_pkg::SCORE_W;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_CHECK, ST_DECIDE, ST_FINISH} state_t;

  state_t         state;
  logic [CW-1:0]  n;
  logic           ovf;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  kc;
  logic           first;
  logic [SW-1:0]  prev_s;
  logic [AW-1:0]  prev_i;
  logic           sc_v;
  logic [AW-1:0]  sc_idx;
  logic           best_v;
  logic [SW-1:0]  best_s;
  logic [AW-1:0]  best_i;
  logic [FW-1:0]  best_data;
  logic           pend_v;
  logic [FW-1:0]  pend_data;
  logic [FW-1:0]  out_data;
  logic           hit;
  logic           v0, v1, v2, v3, v4;

  logic [SW-1:0]  sc_s;
  logic           sc_after;
  logic           out_free;
  logic           out_load;
  logic           k_rd_en;
  logic           k_wr_en;
  logic [4*CB-1:0] kd;

  logic signed [CB-1:0] cx1, cy1, cx2, cy2, kx1, ky1, kx2, ky2;
  logic signed [CB-1:0] xx1, yy1, xx2, yy2;
  logic signed [DW-1:0] w_raw, h_raw;
  logic signed [DW-1:0] w_r, h_r, dcx_r, dcy_r, dkx_r, dky_r;
  logic signed [PW-1:0] inter_r, area_c_r, area_k_r;
  logic signed [UW-1:0] uni_r;
  logic signed [PW-1:0] inter3_r;
  logic signed [MW-1:0] lhs_r, rhs_r;

  gbs_ram #(.W(4*CB), .D(MAX_BOXES)) u_kept (
    .clk     (clk),
    .wr_en   (k_wr_en),
    .wr_addr (kc[AW-1:0]),
    .wr_data (best_data[4*CB-1:0]),
    .rd_en   (k_rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (kd)
  );

  assign out_free    = !m_tvalid || m_tready;
  assign out_load    = ((state == ST_DECIDE) && !hit && pend_v && out_free) ||
                       ((state == ST_FINISH) && out_free);
  assign job_pop     = (state == ST_IDLE) && job_valid;
  assign box_rd_en   = (state == ST_SCAN) && (idx < n);
  assign box_rd_addr = idx[AW-1:0];
  assign k_rd_en     = (state == ST_CHECK) && (idx < kc);
  assign k_wr_en     = (state == ST_DECIDE) && !hit && (!pend_v || out_free);
  assign set_done    = (state == ST_FINISH) && out_free;

  assign sc_s     = box_rd_data[4*CB +: SW];
  assign sc_after = first || (sc_s < prev_s) || ((sc_s == prev_s) && (sc_idx > prev_i));

  assign m_tdata  = TW'(out_data);

  assign cx1 = $signed(best_data[0*CB +: CB]);
  assign cy1 = $signed(best_data[1*CB +: CB]);
  assign cx2 = $signed(best_data[2*CB +: CB]);
  assign cy2 = $signed(best_data[3*CB +: CB]);
  assign kx1 = $signed(kd[0*CB +: CB]);
  assign ky1 = $signed(kd[1*CB +: CB]);
  assign kx2 = $signed(kd[2*CB +: CB]);
  assign ky2 = $signed(kd[3*CB +: CB]);

  always_comb begin
    xx1   = (cx1 > kx1) ? cx1 : kx1;
    yy1   = (cy1 > ky1) ? cy1 : ky1;
    xx2   = (cx2 < kx2) ? cx2 : kx2;
    yy2   = (cy2 < ky2) ? cy2 : ky2;
    w_raw = DW'(xx2) - DW'(xx1) + DW'(gbs_pkg::ONE_PIXEL);
    h_raw = DW'(yy2) - DW'(yy1) + DW'(gbs_pkg::ONE_PIXEL);
  end

  // Overlap test pipeline, one kept box per cycle.
  always_ff @(posedge clk) begin
    w_r      <= (w_raw < 0) ? '0 : w_raw;
    h_r      <= (h_raw < 0) ? '0 : h_raw;
    dcx_r    <= DW'(cx2) - DW'(cx1) + DW'(gbs_pkg::ONE_PIXEL);
    dcy_r    <= DW'(cy2) - DW'(cy1) + DW'(gbs_pkg::ONE_PIXEL);
    dkx_r    <= DW'(kx2) - DW'(kx1) + DW'(gbs_pkg::ONE_PIXEL);
    dky_r    <= DW'(ky2) - DW'(ky1) + DW'(gbs_pkg::ONE_PIXEL);
    inter_r  <= w_r * h_r;
    area_c_r <= dcx_r * dcy_r;
    area_k_r <= dkx_r * dky_r;
    uni_r    <= UW'(area_c_r) + UW'(area_k_r) - UW'(inter_r);
    inter3_r <= inter_r;
    lhs_r    <= MW'(inter3_r) <<< gbs_pkg::THR_SHIFT;
    rhs_r    <= MW'($signed({1'b0, thr})) * MW'(uni_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      pend_v   <= 1'b0;
      sc_v     <= 1'b0;
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      n        <= '0;
      kc       <= '0;
      idx      <= '0;
      ovf      <= 1'b0;
      first    <= 1'b1;
      best_v   <= 1'b0;
      hit      <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      v0 <= k_rd_en;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            n      <= CW'(job.count);
            ovf    <= job.overflow;
            kc     <= '0;
            idx    <= '0;
            first  <= 1'b1;
            best_v <= 1'b0;
            sc_v   <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          sc_v   <= box_rd_en;
          sc_idx <= idx[AW-1:0];
          if (box_rd_en) begin
            idx <= idx + CW'(1);
          end
          if (sc_v && sc_after && (!best_v || (sc_s > best_s))) begin
            best_v    <= 1'b1;
            best_s    <= sc_s;
            best_i    <= sc_idx;
            best_data <= box_rd_data;
          end
          if ((idx == n) && !sc_v) begin
            idx <= '0;
            hit <= 1'b0;
            state <= best_v ? ST_CHECK : ST_FINISH;
          end
        end
        ST_CHECK: begin
          if (k_rd_en) begin
            idx <= idx + CW'(1);
          end
          if (v4 && (lhs_r >= rhs_r)) begin
            hit <= 1'b1;
          end
          if ((idx == kc) && !k_rd_en && !v0 && !v1 && !v2 && !v3 && !v4) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (hit || !pend_v || out_free) begin
            if (!hit) begin
              kc        <= kc + CW'(1);
              pend_data <= best_data;
              pend_v    <= 1'b1;
              if (pend_v) begin
                out_data <= pend_data;
                m_tlast  <= 1'b0;
                m_tuser  <= ovf;
              end
            end
            prev_s <= best_s;
            prev_i <= best_i;
            first  <= 1'b0;
            best_v <= 1'b0;
            idx    <= '0;
            sc_v   <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data <= pend_data;
            m_tlast  <= 1'b1;
            m_tuser  <= ovf;
            pend_v   <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (kc <= n))
    else $error("kept count exceeds loaded count");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (idx <= n))
    else $error("scan index beyond loaded count");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    set_done |=> (m_tvalid && m_tlast))
    else $error("set finished without a final result");
  a_finish_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> pend_v)
    else $error("set finished with no kept box");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/greedy_box_suppression_tb.sv =====
// Self-checking testbench for the greedy box suppression block with a score-ordered predictor.
`timescale 1ns / 100ps
`default_nettype none

class kept_box_board;
  typedef struct packed {
    logic [15:0] x1, y1, x2, y2, score;
    logic [6:0]  label;
    logic        eos, ovf;
  } kept_t;

  logic signed [15:0] cx1[$], cy1[$], cx2[$], cy2[$];
  logic [15:0] scores[$];
  logic [6:0]  labels[$];
  bit          ovf_seen;
  logic [8:0]  thr;
  kept_t       pending[$];
  int          errors;

  function new();
    thr = gbs_pkg::THR_RESET;
    errors = 0;
    ovf_seen = 0;
  endfunction

  function bit covers(int a, int b);
    longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, w, h, inter, uni, area_a, area_b;
    ax1 = cx1[a]; ay1 = cy1[a]; ax2 = cx2[a]; ay2 = cy2[a];
    bx1 = cx1[b]; by1 = cy1[b]; bx2 = cx2[b]; by2 = cy2[b];
    w = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1) + 16;
    h = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1) + 16;
    if (w < 0) w = 0;
    if (h < 0) h = 0;
    inter = w * h;
    area_a = (ax2 - ax1 + 16) * (ay2 - ay1 + 16);
    area_b = (bx2 - bx1 + 16) * (by2 - by1 + 16);
    uni = area_a + area_b - inter;
    return inter * 256 >= longint'(thr) * uni;
  endfunction

  function void note_box(logic [15:0] x1, y1, x2, y2, sc, logic [6:0] lb, bit last);
    int n, ord[$], j, cur;
    bit dead[64];
    kept_t k;
    if (cx1.size() < 64) begin
      cx1.insert(cx1.size(), x1); cy1.insert(cy1.size(), y1);
      cx2.insert(cx2.size(), x2); cy2.insert(cy2.size(), y2);
      scores.insert(scores.size(), sc); labels.insert(labels.size(), lb);
    end else begin
      ovf_seen = 1;
    end
    if (!last) return;
    n = cx1.size();
    for (int i = 0; i < n; i++) begin
      cur = i;
      j = ord.size();
      while (j > 0 && scores[ord[j-1]] < scores[cur]) j--;
      ord.insert(j, cur);
    end
    foreach (dead[i]) dead[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (dead[ord[i]]) continue;
      for (int m = i + 1; m < n; m++)
        if (!dead[ord[m]] && covers(ord[i], ord[m])) dead[ord[m]] = 1;
    end
    j = -1;
    for (int i = 0; i < n; i++) begin
      if (dead[ord[i]]) continue;
      k.x1 = cx1[ord[i]]; k.y1 = cy1[ord[i]]; k.x2 = cx2[ord[i]]; k.y2 = cy2[ord[i]];
      k.score = scores[ord[i]]; k.label = labels[ord[i]];
      k.eos = 0; k.ovf = ovf_seen;
      pending.insert(pending.size(), k);
      j = pending.size() - 1;
    end
    if (j >= 0) pending[j].eos = 1;
    cx1.delete(); cy1.delete(); cx2.delete(); cy2.delete();
    scores.delete(); labels.delete();
    ovf_seen = 0;
  endfunction

  function void check_kept(kept_t got);
    kept_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected kept box, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: kept box mismatch, expected %h, actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module greedy_box_suppression_tb;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tlast = 0, m_tready = 0;
  logic [87:0] s_tdata = '0;
  logic s_tready, m_tvalid, m_tlast, m_tuser, pready;
  logic [87:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  int send_idle, recv_idle, hold_off;
  kept_box_board board;

  greedy_box_suppression u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_kept({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                        m_tdata[79:64], m_tdata[86:80], m_tlast, m_tuser});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_threshold(logic [8:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {gbs_pkg::REG_IOU_THRESHOLD, 2'b00};
    pwdata <= {23'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.thr = value;
  endtask

  task automatic send_box(logic [15:0] x1, y1, x2, y2, sc, logic [6:0] lb, bit last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, lb, sc, y2, x2, y1, x1};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_box(x1, y1, x2, y2, sc, lb, last);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 0;
    while (board.pending.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5000) @(posedge clk);
  endtask

  task automatic random_set(int n, int spread);
    logic [15:0] bx, by, w, h;
    bx = 16'($urandom); by = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 7'($urandom), i == n - 1);
      end else begin
        w = 16'($urandom_range(spread)); h = 16'($urandom_range(spread));
        send_box(16'(bx + $urandom_range(spread)), 16'(by + $urandom_range(spread)),
                 bx + w + 16'($urandom_range(spread)), by + h + 16'($urandom_range(spread)),
                 ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                 7'($urandom), i == n - 1);
      end
    end
  endtask

  initial begin
    board = new();
    send_idle = 0; recv_idle = 0; hold_off = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    // Directed sets: extremes, equal scores, degenerate boxes, single box.
    send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 7'h7f, 1);
    send_box(16'd0, 16'd0, 16'd160, 16'd160, 16'd100, 7'd1, 0);
    send_box(16'd0, 16'd0, 16'd160, 16'd160, 16'd100, 7'd2, 0);
    send_box(16'd8, 16'd8, 16'd168, 16'd168, 16'd200, 7'd3, 0);
    send_box(16'd1000, 16'd1000, 16'd1100, 16'd1100, 16'd0, 7'd4, 0);
    send_box(16'd50, 16'd50, 16'd10, 16'd10, 16'd300, 7'd5, 0);
    send_box(-16'sd16, -16'sd16, -16'sd16, -16'sd16, 16'd50, 7'd0, 1);
    drain();
    write_threshold(9'd0);
    random_set(5, 200);
    drain();
    write_threshold(9'd256);
    random_set(5, 200);
    drain();
    write_threshold(9'd511);
    send_box(16'd0, 16'd0, -16'sd32, -16'sd32, 16'd9, 7'd9, 0);
    send_box(16'd0, 16'd0, 16'd16, 16'd16, 16'd8, 7'd8, 1);
    drain();
    write_threshold(9'd115);
    // Overflow: 66 boxes into a 64 entry store, with a long receiver hold-off.
    hold_off = 400;
    for (int i = 0; i < 66; i++)
      send_box(16'(i * 512), 16'd0, 16'(i * 512 + 100), 16'd100, 16'($urandom), 7'(i),
               i == 65);
    drain();
    send_idle = 14; recv_idle = 74;
    for (int s = 0; s < 3; s++) random_set($urandom_range(1, 4), 400);
    drain();
    write_threshold(9'($urandom_range(256)));
    send_idle = 74; recv_idle = 14;
    for (int s = 0; s < 3; s++) random_set($urandom_range(1, 4), 400);
    drain();
    write_threshold(9'($urandom_range(256)));
    send_idle = 0; recv_idle = 0;
    // The receiver holds off long enough for the output to back up and stall the input.
    hold_off = 3000;
    for (int s = 0; s < 3; s++) random_set($urandom_range(1, 4), 800);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
